### hdl/lr_pkg.sv
package lr_pkg;

   // Coordinate width, fixed by the request and pixel field widths.
   localparam int LR_COORD_BITS = 6;

   // Signed error term width: holds -2*dx .. 2*dy with headroom.
   localparam int LR_ERR_BITS = LR_COORD_BITS + 3;

   // Depth of the queue between the front and the back.
   localparam int LR_QUEUE_DEPTH = 2;

   typedef logic [LR_COORD_BITS-1:0] coord_type;
   typedef logic [LR_ERR_BITS-1:0] err_type;

   // One line request.
   typedef struct packed {
      coord_type  start_x;
      coord_type  start_y;
      coord_type  end_x;
      coord_type  end_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   // One pixel result.
   typedef struct packed {
      coord_type  pixel_x;
      coord_type  pixel_y;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_pixel;
   } rsp_type;

   // Octant folding flags.
   typedef struct packed {
      logic steep;
      logic neg_x;
      logic neg_y;
   } fold_type;

   // A classified line, handed from the front to the back.
   typedef struct packed {
      coord_type  start_x;
      coord_type  start_y;
      coord_type  major;
      coord_type  minor;
      err_type    err_init;
      fold_type   fold;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } desc_type;

endpackage

### hdl/lr_front.sv
module lr_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  lr_pkg::req_type   req_payload,
   output logic              push_valid,
   input  logic              push_ready,
   output lr_pkg::desc_type  push_data
);
   import lr_pkg::*;

   logic [LR_COORD_BITS:0]   diff_x;
   logic [LR_COORD_BITS:0]   diff_y;
   logic [LR_COORD_BITS:0]   abs_x;
   logic [LR_COORD_BITS:0]   abs_y;
   coord_type                major;
   coord_type                minor;
   fold_type                 fold;

   // Signed deltas and their magnitudes.
   always_comb begin
      diff_x = {1'b0, req_payload.end_x} - {1'b0, req_payload.start_x};
      diff_y = {1'b0, req_payload.end_y} - {1'b0, req_payload.start_y};
      fold.neg_x = diff_x[LR_COORD_BITS];
      fold.neg_y = diff_y[LR_COORD_BITS];
      abs_x = fold.neg_x ? (~diff_x + 1'b1) : diff_x;
      abs_y = fold.neg_y ? (~diff_y + 1'b1) : diff_y;
      // A tie in steepness stays on the x axis.
      fold.steep = abs_y[LR_COORD_BITS-1:0] > abs_x[LR_COORD_BITS-1:0];
      major = fold.steep ? abs_y[LR_COORD_BITS-1:0] : abs_x[LR_COORD_BITS-1:0];
      minor = fold.steep ? abs_x[LR_COORD_BITS-1:0] : abs_y[LR_COORD_BITS-1:0];
   end

   // Build the descriptor with the starting error term 2*minor - major.
   always_comb begin
      push_data.start_x  = req_payload.start_x;
      push_data.start_y  = req_payload.start_y;
      push_data.major    = major;
      push_data.minor    = minor;
      push_data.err_init = {2'b00, minor, 1'b0} - {3'b000, major};
      push_data.fold     = fold;
      push_data.red      = req_payload.red;
      push_data.green    = req_payload.green;
      push_data.blue     = req_payload.blue;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

### hdl/lr_queue.sv
module lr_queue #(
   parameter int DEPTH = lr_pkg::LR_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lr_pkg::desc_type  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lr_pkg::desc_type  pop_data
);
   import lr_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   desc_type              mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [PTR_BITS:0]     count_ff;
   logic [PTR_BITS:0]     count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = count_ff != DEPTH[PTR_BITS:0];
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/lr_back.sv
module lr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  lr_pkg::desc_type  pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lr_pkg::rsp_type   rsp_payload
);
   import lr_pkg::*;

   logic      busy_ff;
   logic      busy_in;
   desc_type  line_ff;
   desc_type  line_in;
   coord_type step_ff;
   coord_type step_in;
   coord_type side_ff;
   coord_type side_in;
   err_type   err_ff;
   err_type   err_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      emit;
   logic      last;
   coord_type off_x;
   coord_type off_y;

   assign pop_ready = !busy_ff;
   assign emit      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign last      = step_ff == line_ff.major;

   // Unfold the current point: swap, then negate, then offset.
   always_comb begin
      off_x = line_ff.fold.steep ? side_ff : step_ff;
      off_y = line_ff.fold.steep ? step_ff : side_ff;
      rsp_in.pixel_x    = line_ff.fold.neg_x ? line_ff.start_x - off_x
                                             : line_ff.start_x + off_x;
      rsp_in.pixel_y    = line_ff.fold.neg_y ? line_ff.start_y - off_y
                                             : line_ff.start_y + off_y;
      rsp_in.red_out    = line_ff.red;
      rsp_in.green_out  = line_ff.green;
      rsp_in.blue_out   = line_ff.blue;
      rsp_in.last_pixel = last;
   end

   // Walk control: load a line from the queue, then one step per pixel.
   always_comb begin
      busy_in      = busy_ff;
      line_in      = line_ff;
      step_in      = step_ff;
      side_in      = side_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (!busy_ff) begin
         if (pop_valid) begin
            busy_in = 1'b1;
            line_in = pop_data;
            step_in = '0;
            side_in = '0;
            err_in  = pop_data.err_init;
         end
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         step_in      = step_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
         // A strictly positive error moves the minor axis by one.
         if (!err_ff[LR_ERR_BITS-1] && err_ff != '0) begin
            side_in = side_ff + 1'b1;
            err_in  = err_ff + {2'b00, line_ff.minor, 1'b0}
                             - {2'b00, line_ff.major, 1'b0};
         end else begin
            err_in  = err_ff + {2'b00, line_ff.minor, 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk datapath and output register.
   always_ff @(posedge clock) begin
      line_ff <= line_in;
      step_ff <= step_in;
      side_ff <= side_in;
      err_ff  <= err_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hdl/line_rasterizer_top.sv
// Path: while the walk is idle, a request accepted from the front passes the queue, the line
// load and the pixel output register before its first pixel shows on rsp; a request taken
// during a walk waits in the queue for it to end. Throughput: the walk emits one pixel per
// cycle while rsp_ready does not stall it, and goes idle after a line's last pixel to load the next line.
// A two-entry queue lets the front accept up to two further requests during a walk.
// Reset (synchronous, active high) empties the queue, stops the walk and drops rsp_valid.
module line_rasterizer_top #(
   parameter int QUEUE_DEPTH = lr_pkg::LR_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lr_pkg::req_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lr_pkg::rsp_type  rsp_payload
);
   import lr_pkg::*;

   logic     push_valid;
   logic     push_ready;
   desc_type push_data;
   logic     pop_valid;
   logic     pop_ready;
   desc_type pop_data;

   // Classify each request into a folded line descriptor.
   lr_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // Decoupling queue between the front and the walk.
   lr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Bresenham walk and pixel output register.
   lr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/lr_checker.sv
module lr_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  lr_pkg::req_type  req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  lr_pkg::rsp_type  rsp_payload
);
   import lr_pkg::*;

   logic      rsp_accept;
   logic      mid_line_ff;
   rsp_type   prev_ff;
   coord_type step_x;
   coord_type step_y;

   assign rsp_accept = rsp_valid && rsp_ready;
   assign step_x     = rsp_payload.pixel_x - prev_ff.pixel_x;
   assign step_y     = rsp_payload.pixel_y - prev_ff.pixel_y;

   // Track the last delivered pixel and whether a line is still open.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_line_ff <= 1'b0;
      end else if (rsp_accept) begin
         mid_line_ff <= !rsp_payload.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_accept) begin
         prev_ff <= rsp_payload;
      end
   end

   // A stalled pixel stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled pixel changed or dropped");

   // Reset leaves no pixel on the output.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid right after reset");

   // Every pixel of one line carries the same color.
   a_color_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && mid_line_ff |->
         rsp_payload.red_out == prev_ff.red_out &&
         rsp_payload.green_out == prev_ff.green_out &&
         rsp_payload.blue_out == prev_ff.blue_out)
      else $error("color changed within a line");

   // Consecutive pixels of one line are neighbors on both axes.
   a_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && mid_line_ff |->
         (step_x == '0 || step_x == coord_type'(1) || step_x == '1) &&
         (step_y == '0 || step_y == coord_type'(1) || step_y == '1) &&
         !(step_x == '0 && step_y == '0))
      else $error("pixel is not next to the previous one");

   // A stalled request stays offered and unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("stalled request changed or dropped");

endmodule

bind line_rasterizer_top lr_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### verif/line_rasterizer_top_test.sv
module line_rasterizer_top_test;
   import lr_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 8;
   localparam int COORD_MAX       = (1 << LR_COORD_BITS) - 1;
   localparam int STALL_LIMIT     = 2000;
   localparam int RUN_LIMIT       = 1000000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int REPORT_LIMIT    = 10;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Pixels the walk should still produce, oldest first.
   rsp_type pending_pixels[$];

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int error_count    = 0;
   int lines_sent     = 0;
   int steep_lines    = 0;
   int point_lines    = 0;
   int pixels_checked = 0;
   int quiet_cycles   = 0;
   int run_cycles     = 0;

   line_rasterizer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #CLOCK_HALF clock = ~clock;

   // Fold the line into the first octant, walk it, and queue every pixel.
   function automatic void rasterize_line(input req_type line);
      int       dx;
      int       dy;
      int       swap;
      int       err;
      int       fy;
      int       px;
      int       py;
      fold_type fold;
      rsp_type  pix;
      dx = int'(line.end_x) - int'(line.start_x);
      dy = int'(line.end_y) - int'(line.start_y);
      fold = '0;
      if (dy < 0) begin
         fold.neg_y = 1'b1;
         dy = -dy;
      end
      if (dx < 0) begin
         fold.neg_x = 1'b1;
         dx = -dx;
      end
      // A tie between the axes stays shallow.
      if (dy > dx) begin
         fold.steep = 1'b1;
         swap = dx;
         dx = dy;
         dy = swap;
      end
      if (fold.steep) steep_lines++;
      if (dx == 0) point_lines++;
      err = 2 * dy - dx;
      fy = 0;
      for (int fx = 0; fx <= dx; fx++) begin
         px = fold.steep ? fy : fx;
         py = fold.steep ? fx : fy;
         if (fold.neg_x) px = -px;
         if (fold.neg_y) py = -py;
         pix.pixel_x    = coord_type'(px + int'(line.start_x));
         pix.pixel_y    = coord_type'(py + int'(line.start_y));
         pix.red_out    = line.red;
         pix.green_out  = line.green;
         pix.blue_out   = line.blue;
         pix.last_pixel = (fx == dx);
         pending_pixels = {pending_pixels, pix};
         if (err > 0) begin
            fy++;
            err += 2 * (dy - dx);
         end else begin
            err += 2 * dy;
         end
      end
   endfunction

   function automatic req_type line_of(input int sx, input int sy, input int ex, input int ey,
                                       input logic [31:0] rgb);
      req_type line;
      line.start_x = coord_type'(sx);
      line.start_y = coord_type'(sy);
      line.end_x   = coord_type'(ex);
      line.end_y   = coord_type'(ey);
      {line.red, line.green, line.blue} = rgb[23:0];
      return line;
   endfunction

   function automatic coord_type clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > COORD_MAX) return coord_type'(COORD_MAX);
      return coord_type'(v);
   endfunction

   // Offer one line request, idling first at the current sender rate.
   task automatic send_line(input req_type line);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= line;
      do @(posedge clock); while (!req_ready);
      rasterize_line(line);
      lines_sent++;
   endtask

   // Hold off new requests until every queued pixel has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic test_single_points();
      send_line(line_of(0, 0, 0, 0, $urandom));
      send_line(line_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, $urandom));
      send_line(line_of(0, COORD_MAX, 0, COORD_MAX, $urandom));
      send_line(line_of(COORD_MAX, 0, COORD_MAX, 0, $urandom));
   endtask

   task automatic test_axis_lines();
      send_line(line_of(0, 0, COORD_MAX, 0, $urandom));
      send_line(line_of(COORD_MAX, 5, 0, 5, $urandom));
      send_line(line_of(7, 0, 7, COORD_MAX, $urandom));
      send_line(line_of(9, COORD_MAX, 9, 0, $urandom));
   endtask

   // Full-length diagonals, where both axes tie.
   task automatic test_diagonals();
      send_line(line_of(0, 0, COORD_MAX, COORD_MAX, $urandom));
      send_line(line_of(COORD_MAX, COORD_MAX, 0, 0, $urandom));
      send_line(line_of(0, COORD_MAX, COORD_MAX, 0, $urandom));
      send_line(line_of(COORD_MAX, 0, 0, COORD_MAX, $urandom));
   endtask

   // One line into each octant from a common center.
   task automatic test_octants();
      send_line(line_of(32, 32, 40, 35, $urandom));
      send_line(line_of(32, 32, 35, 40, $urandom));
      send_line(line_of(32, 32, 24, 35, $urandom));
      send_line(line_of(32, 32, 29, 40, $urandom));
      send_line(line_of(32, 32, 24, 29, $urandom));
      send_line(line_of(32, 32, 29, 24, $urandom));
      send_line(line_of(32, 32, 40, 29, $urandom));
      send_line(line_of(32, 32, 35, 24, $urandom));
   endtask

   task automatic test_color_extremes();
      send_line(line_of(3, 4, 6, 5, 32'h00000000));
      send_line(line_of(6, 5, 3, 4, 32'h00FFFFFF));
      send_line(line_of(10, 1, 12, 8, 32'h00AA55AA));
   endtask

   // Random lines, weighted toward short, axis-aligned, diagonal and point cases.
   task automatic test_random_lines(input int count);
      req_type line;
      int      kind;
      int      span;
      int      off;
      for (int i = 0; i < count; i++) begin
         line.start_x = coord_type'($urandom);
         line.start_y = coord_type'($urandom);
         line.end_x   = coord_type'($urandom);
         line.end_y   = coord_type'($urandom);
         line.red     = 8'($urandom);
         line.green   = 8'($urandom);
         line.blue    = 8'($urandom);
         kind = $urandom_range(9);
         case (kind)
            4, 5: begin
               off = $urandom_range(6);
               line.end_x = clamp_coord(int'(line.start_x) + off - 3);
               off = $urandom_range(6);
               line.end_y = clamp_coord(int'(line.start_y) + off - 3);
            end
            6: begin
               line.end_y = line.start_y;
            end
            7: begin
               line.end_x = line.start_x;
            end
            8: begin
               span = $urandom_range(COORD_MAX);
               line.start_x = coord_type'($urandom_range(COORD_MAX - span));
               line.end_x   = coord_type'(int'(line.start_x) + span);
               line.start_y = coord_type'($urandom_range(COORD_MAX - span));
               line.end_y   = coord_type'(int'(line.start_y) + span);
               if ($urandom_range(1)) {line.start_x, line.end_x} = {line.end_x, line.start_x};
               if ($urandom_range(1)) {line.start_y, line.end_y} = {line.end_y, line.start_y};
            end
            9: begin
               line.end_x = line.start_x;
               line.end_y = line.start_y;
            end
            default: begin
            end
         endcase
         send_line(line);
         if ($urandom_range(49) == 0) wait_for_drain();
      end
   endtask

   // Compare each accepted pixel with the oldest expected one, then pick the next ready.
   always @(posedge clock) begin : check_pixels
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h last=%0b",
                        rsp_payload.pixel_x, rsp_payload.pixel_y, rsp_payload.red_out,
                        rsp_payload.green_out, rsp_payload.blue_out, rsp_payload.last_pixel);
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_payload.pixel_x !== want.pixel_x || rsp_payload.pixel_y !== want.pixel_y ||
                rsp_payload.red_out !== want.red_out ||
                rsp_payload.green_out !== want.green_out ||
                rsp_payload.blue_out !== want.blue_out ||
                rsp_payload.last_pixel !== want.last_pixel) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("pixel mismatch: expected x=%0d y=%0d rgb=%02h%02h%02h last=%0b, %s",
                           want.pixel_x, want.pixel_y, want.red_out, want.green_out,
                           want.blue_out, want.last_pixel,
                           $sformatf("got x=%0d y=%0d rgb=%02h%02h%02h last=%0b",
                                     rsp_payload.pixel_x, rsp_payload.pixel_y,
                                     rsp_payload.red_out, rsp_payload.green_out,
                                     rsp_payload.blue_out, rsp_payload.last_pixel));
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // End the run if neither channel moves for too long, or if the run goes on far too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      run_cycles <= run_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no request or pixel moved for %0d cycles", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end
      if (run_cycles >= RUN_LIMIT) begin
         $display("watchdog: run still going after %0d cycles", RUN_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender mostly busy, receiver mostly idle.
      send_idle_pct = 37;
      recv_idle_pct = 66;
      test_single_points();
      test_axis_lines();
      test_diagonals();
      test_octants();
      test_color_extremes();
      wait_for_drain();
      test_random_lines(130);
      wait_for_drain();

      // Sender mostly idle, receiver mostly busy.
      send_idle_pct = 66;
      recv_idle_pct = 37;
      test_random_lines(130);
      wait_for_drain();

      // Both sides at full rate.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lines(130);
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         error_count++;
         $display("%0d expected pixels never arrived", pending_pixels.size());
      end

      $display("Drew %0d lines (%0d steep, %0d single-point) and checked %0d pixels,",
               lines_sent, steep_lines, point_lines, pixels_checked);
      $display("across slow-sender, slow-receiver and full-rate pacing; %0d errors.",
               error_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
